FILE: design/bvi_pkg.sv
// ----------------------------------------------------------------------------
// bvi_pkg: shared types and constants for the body table integrator
// Word formats, command and status codes, datapath micro-ops, the
// controller/datapath command and status bundles, and Q24.24 helpers.
// ----------------------------------------------------------------------------
package bvi_pkg;

    // Sizes
    localparam int TABLE_DEPTH = 64;
    localparam int DATA_W      = 48;
    localparam int TS_W        = 32;
    localparam int IDX_W       = 6;
    localparam int CNT_OUT_W   = 7;
    localparam int STEP_W      = 4;
    localparam int DIV_STEPS   = 49;

    localparam logic [TS_W-1:0] TS_RESET = 32'd279620;

    // Q24.24 constants
    localparam logic signed [DATA_W-1:0] Q_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN  = 48'sh8000_0000_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF = 48'sh0000_0080_0000;

    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_ADD      = 3'd1,
        CMD_REMOVE   = 3'd2,
        CMD_FORCE    = 3'd3,
        CMD_INIT_ACC = 3'd4,
        CMD_INT_POS  = 3'd5,
        CMD_INT_VEL  = 3'd6,
        CMD_RESERVED = 3'd7
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_IDX   = 2'd2,
        ST_ZERO_MASS = 2'd3
    } status_t;

    // Datapath micro-ops; all but the two position adds use the multiplier
    typedef enum logic [3:0] {
        MOP_AX_FI  = 4'd0,   // acc_x = frc_x * inv
        MOP_AY_FI  = 4'd1,
        MOP_NX     = 4'd2,   // tmp = frc_x * inv
        MOP_HX     = 4'd3,   // tmp2 = half * (acc_x + tmp), acc_x = tmp
        MOP_VX     = 4'd4,   // vel_x += tmp2 * dt
        MOP_NY     = 4'd5,
        MOP_HY     = 4'd6,
        MOP_VY     = 4'd7,
        MOP_ADT_X  = 4'd8,   // tmp = acc_x * dt
        MOP_ADT_Y  = 4'd9,
        MOP_TDT    = 4'd10,  // tmp = tmp * dt
        MOP_THALF  = 4'd11,  // tmp = tmp * half
        MOP_PVX    = 4'd12,  // pos_x += vel_x * dt
        MOP_PVY    = 4'd13,
        MOP_PTX    = 4'd14,  // pos_x += tmp (no multiply)
        MOP_PTY    = 4'd15
    } mop_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_CLR  = 2'd1,
        CNT_INC  = 2'd2,
        CNT_DEC  = 2'd3
    } cnt_op_t;

    typedef struct packed {
        logic [2:0]               cmd;
        logic [IDX_W-1:0]         body_index;
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic [DATA_W-1:0]        new_mass;
        logic [DATA_W-1:0]        new_radius;
        logic [7:0]               new_kind;
        logic [7:0]               new_parent;
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
    } req_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]         result_index;
        logic [CNT_OUT_W-1:0]     body_count;
        logic signed [DATA_W-1:0] out_pos_x;
        logic signed [DATA_W-1:0] out_pos_y;
        logic signed [DATA_W-1:0] out_vel_x;
        logic signed [DATA_W-1:0] out_vel_y;
        logic signed [DATA_W-1:0] out_acc_x;
        logic signed [DATA_W-1:0] out_acc_y;
        logic [1:0]               status;
    } res_word_t;

    // One table entry as stored in RAM
    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] acc_x;
        logic signed [DATA_W-1:0] acc_y;
        logic signed [DATA_W-1:0] frc_x;
        logic signed [DATA_W-1:0] frc_y;
        logic [DATA_W-1:0]        mass;
        logic signed [DATA_W-1:0] inv_mass;
        logic [DATA_W-1:0]        radius;
        logic [7:0]               kind;
        logic [7:0]               parent;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic    latch;
        logic    ram_re;
        logic    rd_last;
        logic    load_ent;
        logic    div_start;
        logic    new_ent;
        logic    mul_start;
        logic    alu;
        mop_t    mop;
        logic    add_force;
        logic    ram_we;
        logic    wr_tail;
        cnt_op_t cnt_op;
        logic    out_load;
        status_t out_status;
        logic    out_show;
    } dp_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       bad_idx;
        logic       full;
        logic       mass_zero;
        logic       mul_done;
        logic       div_done;
    } dp_sts_t;

    // Saturating 48-bit signed add
    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? Q_MIN : Q_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    // Micro-op sequence of each arithmetic command
    function automatic mop_t mop_at(input logic [2:0] cmd, input logic [STEP_W-1:0] step);
        mop_t m;
        m = MOP_AX_FI;
        case (cmd)
            CMD_INIT_ACC: m = (step == 4'd0) ? MOP_AX_FI : MOP_AY_FI;
            CMD_INT_POS: begin
                case (step)
                    4'd0:    m = MOP_ADT_X;
                    4'd1:    m = MOP_TDT;
                    4'd2:    m = MOP_THALF;
                    4'd3:    m = MOP_PVX;
                    4'd4:    m = MOP_PTX;
                    4'd5:    m = MOP_ADT_Y;
                    4'd6:    m = MOP_TDT;
                    4'd7:    m = MOP_THALF;
                    4'd8:    m = MOP_PVY;
                    default: m = MOP_PTY;
                endcase
            end
            CMD_INT_VEL: begin
                case (step)
                    4'd0:    m = MOP_NX;
                    4'd1:    m = MOP_HX;
                    4'd2:    m = MOP_VX;
                    4'd3:    m = MOP_NY;
                    4'd4:    m = MOP_HY;
                    default: m = MOP_VY;
                endcase
            end
            default: m = MOP_AX_FI;
        endcase
        return m;
    endfunction

    function automatic logic [STEP_W-1:0] seq_last(input logic [2:0] cmd);
        logic [STEP_W-1:0] n;
        case (cmd)
            CMD_INT_POS: n = 4'd9;
            CMD_INT_VEL: n = 4'd5;
            default:     n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic is_alu(input mop_t m);
        return (m == MOP_PTX) || (m == MOP_PTY);
    endfunction

endpackage

FILE: design/bvi_ram.sv
// ----------------------------------------------------------------------------
// bvi_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bvi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bvi_mul.sv
// ----------------------------------------------------------------------------
// bvi_mul: sequential Q24.24 multiplier
// Sign/magnitude, four 24x24 partial products, round to nearest on the
// magnitude (ties away from zero), saturate to 48 bits. Done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module bvi_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [bvi_pkg::DATA_W-1:0] op_a,
    input  logic signed [bvi_pkg::DATA_W-1:0] op_b,
    output logic                              done,
    output logic signed [bvi_pkg::DATA_W-1:0] product
);
    import bvi_pkg::*;

    localparam logic [2:0] PH_MAG   = 3'd0;
    localparam logic [2:0] PH_ROUND = 3'd6;
    localparam int         HW       = DATA_W / 2;

    logic                     run_reg;
    logic [2:0]               ph_reg;
    logic                     done_reg;
    logic signed [DATA_W-1:0] a_reg, b_reg;
    logic [DATA_W-1:0]        ua_reg, ub_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        pp_reg;
    logic [2*DATA_W-1:0]      acc_reg;
    logic signed [DATA_W-1:0] prod_reg;

    logic [1:0]               k_mul, k_acc;
    logic [HW-1:0]            fa, fb;
    logic [DATA_W-1:0]        pp_next;
    logic [2*DATA_W-1:0]      addend;
    logic [2*DATA_W-1:0]      rsum;
    logic [DATA_W+HW-1:0]     rq;
    logic                     big;
    logic signed [DATA_W-1:0] rounded;
    logic                     mul_ph, acc_ph;

    // partial product select and rounding
    always_comb
    begin
        k_mul  = 2'(ph_reg - 3'd1);
        k_acc  = 2'(ph_reg - 3'd2);
        mul_ph = (ph_reg >= 3'd1) && (ph_reg <= 3'd4);
        acc_ph = (ph_reg >= 3'd2) && (ph_reg <= 3'd5);
        case (k_mul)
            2'd0:    begin fa = ua_reg[HW-1:0];      fb = ub_reg[HW-1:0];      end
            2'd1:    begin fa = ua_reg[HW-1:0];      fb = ub_reg[DATA_W-1:HW]; end
            2'd2:    begin fa = ua_reg[DATA_W-1:HW]; fb = ub_reg[HW-1:0];      end
            default: begin fa = ua_reg[DATA_W-1:HW]; fb = ub_reg[DATA_W-1:HW]; end
        endcase
        pp_next = fa * fb;
        case (k_acc)
            2'd0:    addend = {{DATA_W{1'b0}}, pp_reg};
            2'd1,
            2'd2:    addend = {{HW{1'b0}}, pp_reg, {HW{1'b0}}};
            default: addend = {pp_reg, {DATA_W{1'b0}}};
        endcase
        rsum = acc_reg + {{(DATA_W+HW+1){1'b0}}, {(HW-1){1'b0}}} + (96'd1 << (HW - 1));
        rq   = rsum[2*DATA_W-1:HW];
        big  = |rq[DATA_W+HW-1:DATA_W-1];
        if (big)
        begin
            rounded = neg_reg ? Q_MIN : Q_MAX;
        end
        else if (neg_reg)
        begin
            rounded = -signed'(rq[DATA_W-1:0]);
        end
        else
        begin
            rounded = signed'(rq[DATA_W-1:0]);
        end
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            ph_reg   <= PH_MAG;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (ph_reg == PH_ROUND);
            if (start)
            begin
                run_reg <= 1'b1;
                ph_reg  <= PH_MAG;
            end
            else if (run_reg)
            begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg == PH_ROUND)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // operands and accumulation
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        else if (run_reg)
        begin
            if (ph_reg == PH_MAG)
            begin
                ua_reg  <= a_reg[DATA_W-1] ? (~a_reg + 48'd1) : a_reg;
                ub_reg  <= b_reg[DATA_W-1] ? (~b_reg + 48'd1) : b_reg;
                neg_reg <= a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
                acc_reg <= '0;
            end
            if (mul_ph)
            begin
                pp_reg <= pp_next;
            end
            if (acc_ph)
            begin
                acc_reg <= acc_reg + addend;
            end
            if (ph_reg == PH_ROUND)
            begin
                prod_reg <= rounded;
            end
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

FILE: design/bvi_div.sv
// ----------------------------------------------------------------------------
// bvi_div: reciprocal unit for the inverse mass
// Restoring division, one quotient bit per cycle: round(2^48 / mass),
// saturated to the largest positive Q24.24 value.
// ----------------------------------------------------------------------------
module bvi_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bvi_pkg::DATA_W-1:0]        divisor,
    output logic                              done,
    output logic signed [bvi_pkg::DATA_W-1:0] quotient
);
    import bvi_pkg::*;

    localparam logic [5:0] LAST = 6'(DIV_STEPS - 1);

    logic              run_reg;
    logic [5:0]        cnt_reg;
    logic              done_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DATA_W:0]   num_reg, rem_reg, quo_reg;

    logic [DATA_W:0]   trial;
    logic              ge;

    // one trial subtraction per cycle
    always_comb
    begin
        trial = {rem_reg[DATA_W-1:0], num_reg[DATA_W]};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == LAST);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            num_reg <= {1'b1, {DATA_W{1'b0}}} + {2'b00, divisor[DATA_W-1:1]};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[DATA_W-1:0], ge};
            num_reg <= {num_reg[DATA_W-1:0], 1'b0};
        end
    end

    assign done     = done_reg;
    assign quotient = (|quo_reg[DATA_W:DATA_W-1]) ? Q_MAX : signed'(quo_reg[DATA_W-1:0]);

endmodule

FILE: design/bvi_datapath.sv
// ----------------------------------------------------------------------------
// bvi_datapath: entry table, working entry, arithmetic units and result word
// Holds the command word, body count, time step and the entry being worked
// on; runs micro-ops issued by the controller.
// ----------------------------------------------------------------------------
module bvi_datapath #(
    parameter int MAX_BODY_COUNT = bvi_pkg::TABLE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bvi_pkg::dp_ctl_t           ctl,
    output bvi_pkg::dp_sts_t           sts,
    input  bvi_pkg::req_word_t         request,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bvi_pkg::TS_W-1:0]   cfg_data,
    output logic                       done,
    output bvi_pkg::res_word_t         result
);
    import bvi_pkg::*;

    localparam int AW   = $clog2(MAX_BODY_COUNT);
    localparam int CW   = $clog2(MAX_BODY_COUNT + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam int EW   = $bits(entry_t);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BODY_COUNT);

    req_word_t                word_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic [TS_W-1:0]          time_step_reg;
    entry_t                   ent_reg, ent_next;
    logic signed [DATA_W-1:0] tmp_reg, tmp_next, tmp2_reg, tmp2_next;
    mop_t                     mop_reg;
    res_word_t                out_reg;
    logic                     done_reg;

    logic signed [DATA_W-1:0] dt, mul_a, mul_b, mul_p, inv_mass;
    logic                     mul_done, div_done;
    logic [AW-1:0]            raddr, waddr;
    logic [EW-1:0]            rdata;
    entry_t                   wr_ent;
    res_word_t                out_next;

    bvi_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctl.mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    bvi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .divisor  (word_reg.new_mass),
        .done     (div_done),
        .quotient (inv_mass)
    );

    bvi_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BODY_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.ram_we),
        .waddr (waddr),
        .wdata (wr_ent),
        .re    (ctl.ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // status toward the controller
    always_comb
    begin
        sts.cmd       = word_reg.cmd;
        sts.bad_idx   = (word_reg.cmd == CMD_RESERVED) ||
                        (CMPW'(word_reg.body_index) >= CMPW'(count_reg));
        sts.full      = count_reg >= CNT_MAX;
        sts.mass_zero = word_reg.new_mass == '0;
        sts.mul_done  = mul_done;
        sts.div_done  = div_done;
    end

    assign dt        = signed'({{(DATA_W-TS_W){1'b0}}, time_step_reg});
    assign cfg_ready = 1'b1;

    // table addressing; write back clears the force sum after a new accel
    always_comb
    begin
        raddr  = ctl.rd_last ? AW'(count_reg - CW'(1)) : AW'(word_reg.body_index);
        waddr  = ctl.wr_tail ? AW'(count_reg) : AW'(word_reg.body_index);
        wr_ent = ent_reg;
        if (word_reg.cmd == CMD_INIT_ACC || word_reg.cmd == CMD_INT_VEL)
        begin
            wr_ent.frc_x = '0;
            wr_ent.frc_y = '0;
        end
    end

    // multiplier operand select
    always_comb
    begin
        case (ctl.mop)
            MOP_AX_FI, MOP_NX: begin mul_a = ent_reg.frc_x; mul_b = ent_reg.inv_mass; end
            MOP_AY_FI, MOP_NY: begin mul_a = ent_reg.frc_y; mul_b = ent_reg.inv_mass; end
            MOP_HX:    begin mul_a = sat_add(ent_reg.acc_x, tmp_reg); mul_b = Q_HALF; end
            MOP_HY:    begin mul_a = sat_add(ent_reg.acc_y, tmp_reg); mul_b = Q_HALF; end
            MOP_VX, MOP_VY: begin mul_a = tmp2_reg;      mul_b = dt;     end
            MOP_ADT_X: begin mul_a = ent_reg.acc_x; mul_b = dt;     end
            MOP_ADT_Y: begin mul_a = ent_reg.acc_y; mul_b = dt;     end
            MOP_TDT:   begin mul_a = tmp_reg;       mul_b = dt;     end
            MOP_THALF: begin mul_a = tmp_reg;       mul_b = Q_HALF; end
            MOP_PVX:   begin mul_a = ent_reg.vel_x; mul_b = dt;     end
            MOP_PVY:   begin mul_a = ent_reg.vel_y; mul_b = dt;     end
            default:   begin mul_a = '0;            mul_b = '0;     end
        endcase
    end

    // working entry update
    always_comb
    begin
        ent_next  = ent_reg;
        tmp_next  = tmp_reg;
        tmp2_next = tmp2_reg;
        if (ctl.load_ent)
        begin
            ent_next = entry_t'(rdata);
        end
        if (ctl.new_ent)
        begin
            ent_next.pos_x    = word_reg.new_pos_x;
            ent_next.pos_y    = word_reg.new_pos_y;
            ent_next.vel_x    = word_reg.new_vel_x;
            ent_next.vel_y    = word_reg.new_vel_y;
            ent_next.acc_x    = '0;
            ent_next.acc_y    = '0;
            ent_next.frc_x    = '0;
            ent_next.frc_y    = '0;
            ent_next.mass     = word_reg.new_mass;
            ent_next.inv_mass = inv_mass;
            ent_next.radius   = word_reg.new_radius;
            ent_next.kind     = word_reg.new_kind;
            ent_next.parent   = word_reg.new_parent;
        end
        if (ctl.add_force)
        begin
            ent_next.frc_x = sat_add(ent_reg.frc_x, word_reg.force_x);
            ent_next.frc_y = sat_add(ent_reg.frc_y, word_reg.force_y);
        end
        if (ctl.alu)
        begin
            case (ctl.mop)
                MOP_PTX: ent_next.pos_x = sat_add(ent_reg.pos_x, tmp_reg);
                MOP_PTY: ent_next.pos_y = sat_add(ent_reg.pos_y, tmp_reg);
                default: ;
            endcase
        end
        if (mul_done)
        begin
            case (mop_reg)
                MOP_AX_FI: ent_next.acc_x = mul_p;
                MOP_AY_FI: ent_next.acc_y = mul_p;
                MOP_HX:
                begin
                    tmp2_next     = mul_p;
                    ent_next.acc_x = tmp_reg;
                end
                MOP_HY:
                begin
                    tmp2_next     = mul_p;
                    ent_next.acc_y = tmp_reg;
                end
                MOP_VX:  ent_next.vel_x = sat_add(ent_reg.vel_x, mul_p);
                MOP_VY:  ent_next.vel_y = sat_add(ent_reg.vel_y, mul_p);
                MOP_PVX: ent_next.pos_x = sat_add(ent_reg.pos_x, mul_p);
                MOP_PVY: ent_next.pos_y = sat_add(ent_reg.pos_y, mul_p);
                default: tmp_next = mul_p;
            endcase
        end
    end

    // body count
    always_comb
    begin
        case (ctl.cnt_op)
            CNT_CLR: count_next = '0;
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    // result word
    always_comb
    begin
        out_next            = '0;
        out_next.body_count = CNT_OUT_W'(count_reg);
        out_next.status     = ctl.out_status;
        if (word_reg.cmd == CMD_ADD)
        begin
            out_next.result_index = ctl.out_show ? IDX_W'(count_reg - CW'(1)) : '0;
        end
        else if (word_reg.cmd != CMD_CLEAR)
        begin
            out_next.result_index = word_reg.body_index;
        end
        if (ctl.out_show)
        begin
            out_next.out_pos_x = ent_reg.pos_x;
            out_next.out_pos_y = ent_reg.pos_y;
            out_next.out_vel_x = ent_reg.vel_x;
            out_next.out_vel_y = ent_reg.vel_y;
            out_next.out_acc_x = ent_reg.acc_x;
            out_next.out_acc_y = ent_reg.acc_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            time_step_reg <= TS_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= ctl.out_load;
            if (cfg_valid)
            begin
                time_step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        tmp_reg  <= tmp_next;
        tmp2_reg <= tmp2_next;
        if (ctl.latch)
        begin
            word_reg <= request;
        end
        if (ctl.mul_start)
        begin
            mop_reg <= ctl.mop;
        end
        if (ctl.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

    // count stays within the table
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("body count above table size");

    // appends only go to a free slot
    a_tail_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.ram_we && ctl.wr_tail) |-> (count_reg < CNT_MAX))
        else $error("append into full table");

endmodule

FILE: design/bvi_ctrl.sv
// ----------------------------------------------------------------------------
// bvi_ctrl: command sequencer
// Decodes the command word, runs the read / compute / write-back sequence
// and issues the result strobe.
// ----------------------------------------------------------------------------
module bvi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bvi_pkg::dp_sts_t sts,
    output bvi_pkg::dp_ctl_t ctl
);
    import bvi_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_LOAD   = 9'b000000100,
        S_FORCE  = 9'b000001000,
        S_STEP   = 9'b000010000,
        S_MWAIT  = 9'b000100000,
        S_DIVW   = 9'b001000000,
        S_WRITE  = 9'b010000000,
        S_FIN    = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    status_t           status_reg, status_next;
    logic              show_reg, show_next;
    mop_t              cur_mop;
    logic              seq_end;

    assign cur_mop = mop_at(sts.cmd, step_reg);
    assign seq_end = step_reg == seq_last(sts.cmd);

    always_comb
    begin
        ctl         = '0;
        ctl.mop     = cur_mop;
        state_next  = state_reg;
        step_next   = step_reg;
        status_next = status_reg;
        show_next   = show_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = ST_OK;
                show_next   = 1'b0;
                case (sts.cmd)
                    CMD_CLEAR:
                    begin
                        ctl.cnt_op = CNT_CLR;
                        state_next = S_FIN;
                    end
                    CMD_ADD:
                    begin
                        if (sts.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else if (sts.mass_zero)
                        begin
                            status_next = ST_ZERO_MASS;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            ctl.div_start = 1'b1;
                            show_next     = 1'b1;
                            state_next    = S_DIVW;
                        end
                    end
                    default:
                    begin
                        if (sts.bad_idx)
                        begin
                            status_next = ST_BAD_IDX;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            ctl.ram_re  = 1'b1;
                            ctl.rd_last = sts.cmd == CMD_REMOVE;
                            show_next   = 1'b1;
                            state_next  = S_LOAD;
                        end
                    end
                endcase
            end
            S_LOAD:
            begin
                ctl.load_ent = 1'b1;
                step_next    = '0;
                if (sts.cmd == CMD_REMOVE)
                begin
                    state_next = S_WRITE;
                end
                else if (sts.cmd == CMD_FORCE)
                begin
                    state_next = S_FORCE;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_FORCE:
            begin
                ctl.add_force = 1'b1;
                state_next    = S_WRITE;
            end
            S_STEP:
            begin
                if (is_alu(cur_mop))
                begin
                    ctl.alu = 1'b1;
                    if (seq_end)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
                else
                begin
                    ctl.mul_start = 1'b1;
                    state_next    = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    if (seq_end)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        step_next  = step_reg + 4'd1;
                        state_next = S_STEP;
                    end
                end
            end
            S_DIVW:
            begin
                if (sts.div_done)
                begin
                    ctl.new_ent = 1'b1;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ctl.ram_we  = 1'b1;
                ctl.wr_tail = sts.cmd == CMD_ADD;
                if (sts.cmd == CMD_ADD)
                begin
                    ctl.cnt_op = CNT_INC;
                end
                else if (sts.cmd == CMD_REMOVE)
                begin
                    ctl.cnt_op = CNT_DEC;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                ctl.out_load   = 1'b1;
                ctl.out_status = status_reg;
                ctl.out_show   = show_reg;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            status_reg <= ST_OK;
            show_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            status_reg <= status_next;
            show_reg   <= show_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    // arithmetic units only finish while the sequencer waits for them
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mul_done |-> (state_reg == S_MWAIT))
        else $error("multiplier finished outside wait state");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_DIVW))
        else $error("divider finished outside wait state");

endmodule

FILE: design/body_table_verlet_integrator_core.sv
// ----------------------------------------------------------------------------
// body_table_verlet_integrator_core: 2D body table with velocity Verlet
// Top level: command sequencer plus datapath around one table RAM.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy stays
// high until its result word is loaded, and the word is then shown for one
// cycle with done high; the receiver must take it then. A new command may be
// accepted in that same cycle. One command runs at a time. Each Q24.24
// product runs on the single shared multiplier (issue, seven phases for
// magnitudes, four 24x24 partial products and rounding, then done); init
// accel, integrate velocity and integrate position (eight products and two
// adds) use it in turn. Add runs the 49-step reciprocal divider.
// The table RAM has one read and one write port; entries need no clearing
// after reset. The time step register may be written whenever no command is
// in flight.
// ----------------------------------------------------------------------------
module body_table_verlet_integrator_core #(
    parameter int MAX_BODY_COUNT = bvi_pkg::TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  bvi_pkg::req_word_t       request,
    output logic                     done,
    output bvi_pkg::res_word_t       result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [bvi_pkg::TS_W-1:0] cfg_data
);
    import bvi_pkg::*;

    dp_ctl_t ctl;
    dp_sts_t sts;

    bvi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    bvi_datapath #(
        .MAX_BODY_COUNT (MAX_BODY_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule
